FILE: hw/rtl/vfcm_pkg.sv
// ============================================================================
// vfcm_pkg
// Shared types and codes of the voxel face culling mesher: action and result
// kind codes, face directions, sequencer states and fixed field widths.
// ============================================================================
package vfcm_pkg;

   // Fixed field widths of the stream payloads
   localparam int CoordXW   = 4;
   localparam int CoordYW   = 8;
   localparam int CoordZW   = 4;
   localparam int TypeW     = 4;
   localparam int DirW      = 3;
   localparam int VbaseW    = 16;
   localparam int TotalW    = 15;
   localparam int ReqDataW  = 24;
   localparam int RspDataW  = 56;
   localparam int FaceCount = 6;

   localparam logic [TypeW-1:0] TypeAir        = '0;
   localparam logic [TypeW-1:0] TranslucentRst = 4'd6;

   typedef enum logic [1:0] {
      ACT_WRITE  = 2'd0,
      ACT_READ   = 2'd1,
      ACT_MESH   = 2'd2,
      ACT_FINISH = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_READ   = 2'd0,
      KIND_FACE   = 2'd1,
      KIND_TOTALS = 2'd2
   } kind_type;

   typedef enum logic [DirW-1:0] {
      FACE_NX = 3'd0,
      FACE_PX = 3'd1,
      FACE_NY = 3'd2,
      FACE_PY = 3'd3,
      FACE_NZ = 3'd4,
      FACE_PZ = 3'd5
   } face_dir_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_CENTER,
      ST_CHECK,
      ST_NBR,
      ST_NBR_LAST,
      ST_EMIT_FACE,
      ST_EMIT_ONE
   } state_type;

endpackage

FILE: hw/rtl/voxel_face_culling_mesher_unit.sv
// ============================================================================
// voxel_face_culling_mesher_unit
// Voxel chunk store with write, read, per-block face meshing and totals.
// ============================================================================
// After reset the block sweeps the single-port voxel store to air, one entry
// a cycle, over all SIZE_X*SIZE_Y*SIZE_Z entries (65536 at the defaults), and
// takes no beat until the sweep is done; csr writes are taken throughout. One
// beat is worked at a time and the single store port sets the pace. Reads
// and meshes read the center; a read then emits it, an air or out-of-chunk
// mesh ends there, and a solid one does six pipelined neighbor reads, then
// sends a face record per face-state visit while the result register is
// free, with one more visit when no record goes out or faces are dropped
// at the cap. The result register lets the next beat be taken while a
// finished record still waits for rsp_tready.
module voxel_face_culling_mesher_unit #(
   parameter int SIZE_X    = 16,
   parameter int SIZE_Y    = 256,
   parameter int SIZE_Z    = 16,
   parameter int MAX_FACES = 16384
) (
   input  logic                               clock,
   input  logic                               reset,
   // request: x, y, z, type to store, from bit 0 up, zero padded
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [vfcm_pkg::ReqDataW-1:0]      req_tdata,
   input  logic [1:0]                         req_tuser,   // action
   // response: {x, y, z, face_dir, type_out, vertex_base, face_total,
   //            overflow} from bit 0 up, zero padded
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [vfcm_pkg::RspDataW-1:0]      rsp_tdata,
   output logic [1:0]                         rsp_tuser,   // kind
   output logic                               rsp_tlast,
   // translucent type register
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [vfcm_pkg::TypeW-1:0]         csr_data
);

   localparam int Voxels  = SIZE_X * SIZE_Y * SIZE_Z;
   localparam int AddrW   = $clog2(Voxels);
   localparam int StrideY = SIZE_X;
   localparam int StrideZ = SIZE_X * SIZE_Y;
   localparam int CntW    = $clog2(MAX_FACES + 1);

   localparam logic [AddrW-1:0] LastAddr = AddrW'(Voxels - 1);
   localparam logic [AddrW-1:0] StepY    = AddrW'(StrideY);
   localparam logic [AddrW-1:0] StepZ    = AddrW'(StrideZ);
   localparam logic [CntW-1:0]  CapCnt   = CntW'(MAX_FACES);

   // --------------------------------------------------------------------------
   // Registers
   // --------------------------------------------------------------------------
   vfcm_pkg::state_type              state_ff, state_in;
   logic [AddrW-1:0]                 clr_ff, clr_in;
   logic [vfcm_pkg::TypeW-1:0]       transl_ff;
   logic [CntW-1:0]                  cnt_ff, cnt_in;
   logic                             ovf_ff, ovf_in;
   logic [2:0]                       dir_ff, dir_in;
   logic [vfcm_pkg::FaceCount-1:0]   mask_ff, mask_in;
   logic [vfcm_pkg::TypeW-1:0]       type_ff, type_in;

   vfcm_pkg::action_type             act_ff;
   logic [vfcm_pkg::CoordXW-1:0]     x_ff;
   logic [vfcm_pkg::CoordYW-1:0]     y_ff;
   logic [vfcm_pkg::CoordZW-1:0]     z_ff;
   logic [vfcm_pkg::TypeW-1:0]       bt_ff;
   logic [AddrW-1:0]                 addr_ff;
   logic                             ok_ff;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [vfcm_pkg::RspDataW-1:0]    rsp_data_ff, rsp_data_in;
   logic [1:0]                       rsp_user_ff, rsp_user_in;
   logic                             rsp_last_ff, rsp_last_in;

   // Voxel store
   logic [vfcm_pkg::TypeW-1:0]       mem [Voxels];
   logic [vfcm_pkg::TypeW-1:0]       mem_q;
   logic                             mem_we;
   logic [AddrW-1:0]                 mem_addr;
   logic [vfcm_pkg::TypeW-1:0]       mem_wdata;

   // Request decode
   logic                             req_fire;
   logic [vfcm_pkg::CoordXW-1:0]     req_x;
   logic [vfcm_pkg::CoordYW-1:0]     req_y;
   logic [vfcm_pkg::CoordZW-1:0]     req_z;
   logic                             req_ok;
   logic [AddrW-1:0]                 req_addr;

   // Neighbor evaluation and face pick
   logic [vfcm_pkg::FaceCount-1:0]   nbr_out;
   logic [AddrW-1:0]                 nbr_addr;
   logic [2:0]                       eval_dir;
   logic                             show;
   logic                             slot_free;
   logic [2:0]                       pick_dir;
   logic [vfcm_pkg::FaceCount-1:0]   mask_rest;
   logic [CntW-1:0]                  cnt_inc;

   assign req_x     = req_tdata[3:0];
   assign req_y     = req_tdata[11:4];
   assign req_z     = req_tdata[15:12];
   assign req_fire  = req_tvalid && req_tready;
   assign req_tready = (state_ff == vfcm_pkg::ST_IDLE);
   assign req_ok    = (32'(req_x) < SIZE_X) && (32'(req_y) < SIZE_Y) &&
                      (32'(req_z) < SIZE_Z);
   assign req_addr  = AddrW'(32'(req_x) + 32'(req_y) * StrideY + 32'(req_z) * StrideZ);

   assign csr_ready = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // Flag neighbors that fall outside the chunk
   assign nbr_out[vfcm_pkg::FACE_NX] = (x_ff == '0);
   assign nbr_out[vfcm_pkg::FACE_PX] = (32'(x_ff) + 32'd1 >= SIZE_X);
   assign nbr_out[vfcm_pkg::FACE_NY] = (y_ff == '0);
   assign nbr_out[vfcm_pkg::FACE_PY] = (32'(y_ff) + 32'd1 >= SIZE_Y);
   assign nbr_out[vfcm_pkg::FACE_NZ] = (z_ff == '0);
   assign nbr_out[vfcm_pkg::FACE_PZ] = (32'(z_ff) + 32'd1 >= SIZE_Z);

   // Select the neighbor address of the face being read
   always_comb begin
      unique case (vfcm_pkg::face_dir_type'(dir_ff))
         vfcm_pkg::FACE_NX: nbr_addr = addr_ff - AddrW'(1);
         vfcm_pkg::FACE_PX: nbr_addr = addr_ff + AddrW'(1);
         vfcm_pkg::FACE_NY: nbr_addr = addr_ff - StepY;
         vfcm_pkg::FACE_PY: nbr_addr = addr_ff + StepY;
         vfcm_pkg::FACE_NZ: nbr_addr = addr_ff - StepZ;
         vfcm_pkg::FACE_PZ: nbr_addr = addr_ff + StepZ;
         default:           nbr_addr = addr_ff;
      endcase
   end

   // Judge the face whose neighbor data just came back
   assign eval_dir = dir_ff - 3'd1;
   assign show     = nbr_out[eval_dir] ||
                     (mem_q == vfcm_pkg::TypeAir) || (mem_q == transl_ff);

   // Pick the lowest pending face
   always_comb begin
      pick_dir  = '0;
      mask_rest = mask_ff;
      for (int i = vfcm_pkg::FaceCount - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            pick_dir  = 3'(i);
            mask_rest = mask_ff & ~(vfcm_pkg::FaceCount'(1) << i);
         end
      end
   end

   assign cnt_inc = cnt_ff + CntW'(1);

   // --------------------------------------------------------------------------
   // Sequencer: next state, store port and result register load
   // --------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      dir_in       = dir_ff;
      mask_in      = mask_ff;
      type_in      = type_ff;
      mem_we       = 1'b0;
      mem_addr     = addr_ff;
      mem_wdata    = bt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         vfcm_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = vfcm_pkg::TypeAir;
            clr_in    = clr_ff + AddrW'(1);
            if (clr_ff == LastAddr) begin
               state_in = vfcm_pkg::ST_IDLE;
            end
         end
         vfcm_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (vfcm_pkg::action_type'(req_tuser))
                  vfcm_pkg::ACT_WRITE:  state_in = vfcm_pkg::ST_WRITE;
                  vfcm_pkg::ACT_READ,
                  vfcm_pkg::ACT_MESH:   state_in = vfcm_pkg::ST_CENTER;
                  vfcm_pkg::ACT_FINISH: state_in = vfcm_pkg::ST_EMIT_ONE;
                  default:              state_in = vfcm_pkg::ST_IDLE;
               endcase
            end
         end
         vfcm_pkg::ST_WRITE: begin
            mem_we   = ok_ff;
            state_in = vfcm_pkg::ST_IDLE;
         end
         vfcm_pkg::ST_CENTER: begin
            // read the center voxel
            mem_addr = addr_ff;
            state_in = vfcm_pkg::ST_CHECK;
         end
         vfcm_pkg::ST_CHECK: begin
            type_in = ok_ff ? mem_q : vfcm_pkg::TypeAir;
            mask_in = '0;
            if (act_ff == vfcm_pkg::ACT_READ) begin
               state_in = vfcm_pkg::ST_EMIT_ONE;
            end else if (!ok_ff || mem_q == vfcm_pkg::TypeAir) begin
               state_in = vfcm_pkg::ST_IDLE;
            end else begin
               // issue the first neighbor read
               mem_addr = nbr_addr;
               dir_in   = dir_ff + 3'd1;
               state_in = vfcm_pkg::ST_NBR;
            end
         end
         vfcm_pkg::ST_NBR: begin
            mem_addr = nbr_addr;
            mask_in  = mask_ff | (vfcm_pkg::FaceCount'(show) << eval_dir);
            dir_in   = dir_ff + 3'd1;
            if (dir_ff == 3'(vfcm_pkg::FACE_PZ)) begin
               state_in = vfcm_pkg::ST_NBR_LAST;
            end
         end
         vfcm_pkg::ST_NBR_LAST: begin
            mask_in  = mask_ff | (vfcm_pkg::FaceCount'(show) << eval_dir);
            state_in = vfcm_pkg::ST_EMIT_FACE;
         end
         vfcm_pkg::ST_EMIT_FACE: begin
            priority if (mask_ff == '0) begin
               state_in = vfcm_pkg::ST_IDLE;
            end else if (cnt_ff >= CapCnt) begin
               // drop the remaining faces at the cap
               ovf_in   = 1'b1;
               mask_in  = '0;
               state_in = vfcm_pkg::ST_IDLE;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = vfcm_pkg::KIND_FACE;
               rsp_last_in  = (mask_rest == '0) || (cnt_inc >= CapCnt);
               rsp_data_in  = {1'b0, 1'b0, vfcm_pkg::TotalW'(0),
                               vfcm_pkg::VbaseW'({cnt_ff, 2'b00}), type_ff,
                               pick_dir, z_ff, y_ff, x_ff};
               cnt_in       = cnt_inc;
               mask_in      = mask_rest;
               if (mask_rest == '0) begin
                  state_in = vfcm_pkg::ST_IDLE;
               end
            end else begin
               state_in = vfcm_pkg::ST_EMIT_FACE;
            end
         end
         vfcm_pkg::ST_EMIT_ONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (act_ff == vfcm_pkg::ACT_FINISH) begin
                  rsp_user_in = vfcm_pkg::KIND_TOTALS;
                  rsp_data_in = {1'b0, ovf_ff, vfcm_pkg::TotalW'(cnt_ff),
                                 vfcm_pkg::VbaseW'(0), vfcm_pkg::TypeW'(0),
                                 vfcm_pkg::DirW'(0), vfcm_pkg::CoordZW'(0),
                                 vfcm_pkg::CoordYW'(0), vfcm_pkg::CoordXW'(0)};
                  cnt_in      = '0;
                  ovf_in      = 1'b0;
               end else begin
                  rsp_user_in = vfcm_pkg::KIND_READ;
                  rsp_data_in = {1'b0, 1'b0, vfcm_pkg::TotalW'(0),
                                 vfcm_pkg::VbaseW'(0), type_ff,
                                 vfcm_pkg::DirW'(0), z_ff, y_ff, x_ff};
               end
               state_in = vfcm_pkg::ST_IDLE;
            end
         end
         default: state_in = vfcm_pkg::ST_IDLE;
      endcase

      if (req_fire) begin
         dir_in = '0;
      end
   end

   // --------------------------------------------------------------------------
   // Voxel store, single port, registered read
   // --------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      mem_q <= mem[mem_addr];
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vfcm_pkg::ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         transl_ff    <= vfcm_pkg::TranslucentRst;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            transl_ff <= csr_data;
         end
      end
   end

   // Hold the item and the working payload
   always_ff @(posedge clock) begin
      dir_ff      <= dir_in;
      mask_ff     <= mask_in;
      type_ff     <= type_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
      if (req_fire) begin
         act_ff  <= vfcm_pkg::action_type'(req_tuser);
         x_ff    <= req_x;
         y_ff    <= req_y;
         z_ff    <= req_z;
         bt_ff   <= req_tdata[19:16];
         addr_ff <= req_addr;
         ok_ff   <= req_ok;
      end
   end

   // --------------------------------------------------------------------------
   // Assertions
   // --------------------------------------------------------------------------
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CapCnt)
      else $error("face counter beyond cap");

   a_face_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vfcm_pkg::ST_EMIT_FACE && rsp_valid_in && slot_free &&
       mask_ff != '0 && cnt_ff < CapCnt) |=> cnt_ff == $past(cnt_ff) + CntW'(1))
      else $error("face record without counter advance");

   a_ovf_at_cap: assert property (@(posedge clock) disable iff (reset)
      $rose(ovf_ff) |-> cnt_ff == CapCnt)
      else $error("overflow set below cap");

   a_store_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == vfcm_pkg::ST_CLEAR || state_ff == vfcm_pkg::ST_WRITE))
      else $error("store written outside clear or write");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vfcm_pkg::ST_CLEAR) |-> !req_tready)
      else $error("beat taken during clear sweep");

endmodule

FILE: tb/face_mesh_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// face_mesh_checker
// Watches the request, response and csr channels of the voxel face culling
// mesher. It keeps its own chunk store, face counter and overflow flag. From
// them it works out the records that each request beat must produce, and it
// compares every response beat, field by field, with the oldest of them.
// ============================================================================
module face_mesh_checker
   import vfcm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,
   input  logic [1:0]          req_tuser,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [RspDataW-1:0] rsp_tdata,
   input  logic [1:0]          rsp_tuser,
   input  logic                rsp_tlast,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [TypeW-1:0]    csr_data,
   output int                  pending,
   output int                  errors
);

   localparam int ChunkX     = 16;
   localparam int ChunkY     = 256;
   localparam int ChunkZ     = 16;
   localparam int ChunkCells = ChunkX * ChunkY * ChunkZ;
   localparam int FaceCap    = 16384;
   localparam int MaxReports = 60;

   typedef struct packed {
      kind_type              kind;
      logic [CoordXW-1:0]    x;
      logic [CoordYW-1:0]    y;
      logic [CoordZW-1:0]    z;
      logic [DirW-1:0]       dir;
      logic [TypeW-1:0]      blk;
      logic [VbaseW-1:0]     vbase;
      logic [TotalW-1:0]     total;
      logic                  ovf;
      logic                  last;
   } mesh_record;

   logic [TypeW-1:0] chunk_mem [0:ChunkCells-1];
   mesh_record       record_q [$];
   int               faces_used;
   bit               ovf_seen;
   logic [TypeW-1:0] water_type;
   int               fail_count = 0;

   // Count and report one field that differs from its expectation
   task automatic match_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
         if (fail_count < MaxReports)
            $display("%0t ns  %s: expected %0d, actual %0d", $time, what, want, got);
         fail_count++;
      end
   endtask

   // Work out the records of one request beat and update the chunk model
   task automatic predict_beat(action_type act, logic [CoordXW-1:0] bx,
                               logic [CoordYW-1:0] by, logic [CoordZW-1:0] bz,
                               logic [TypeW-1:0] bt);
      mesh_record       rec;
      logic [TypeW-1:0] centre;
      logic [TypeW-1:0] nbr;
      int               nx, ny, nz;
      int               emitted;
      bit               show;
      rec = '0;
      rec.x = bx;
      rec.y = by;
      rec.z = bz;
      case (act)
         ACT_WRITE: chunk_mem[{bz, by, bx}] = bt;
         ACT_READ: begin
            rec.kind = KIND_READ;
            rec.blk  = chunk_mem[{bz, by, bx}];
            rec.last = 1'b1;
            record_q.push_back(rec);
         end
         ACT_FINISH: begin
            rec       = '0;
            rec.kind  = KIND_TOTALS;
            rec.total = faces_used[TotalW-1:0];
            rec.ovf   = ovf_seen;
            rec.last  = 1'b1;
            record_q.push_back(rec);
            faces_used = 0;
            ovf_seen   = 1'b0;
         end
         ACT_MESH: begin
            centre  = chunk_mem[{bz, by, bx}];
            emitted = 0;
            if (centre != TypeAir) begin
               // walk the faces in order; show those not hidden by a solid neighbor
               for (int f = 0; f < FaceCount; f++) begin
                  nx = bx;
                  ny = by;
                  nz = bz;
                  case (face_dir_type'(f))
                     FACE_NX: nx--;
                     FACE_PX: nx++;
                     FACE_NY: ny--;
                     FACE_PY: ny++;
                     FACE_NZ: nz--;
                     default: nz++;
                  endcase
                  if (nx < 0 || nx >= ChunkX || ny < 0 || ny >= ChunkY ||
                      nz < 0 || nz >= ChunkZ) begin
                     show = 1'b1;
                  end else begin
                     nbr  = chunk_mem[nz * ChunkX * ChunkY + ny * ChunkX + nx];
                     show = (nbr == TypeAir) || (nbr == water_type);
                  end
                  if (show) begin
                     if (faces_used >= FaceCap) begin
                        ovf_seen = 1'b1;
                     end else begin
                        rec.kind  = KIND_FACE;
                        rec.dir   = DirW'(f);
                        rec.blk   = centre;
                        rec.vbase = VbaseW'(faces_used * 4);
                        rec.last  = 1'b0;
                        record_q.push_back(rec);
                        faces_used++;
                        emitted++;
                     end
                  end
               end
               // mark the final face of this block
               if (emitted > 0) begin
                  rec = record_q.pop_back();
                  rec.last = 1'b1;
                  record_q.push_back(rec);
               end
            end
         end
         default: ;
      endcase
   endtask

   // Compare one response beat with the oldest expectation
   task automatic compare_beat();
      mesh_record want;
      if (record_q.size() == 0) begin
         if (fail_count < MaxReports)
            $display("%0t ns  response beat with nothing expected: expected none, actual %h",
                     $time, rsp_tdata);
         fail_count++;
      end else begin
         want = record_q.pop_front();
         match_field("kind",        want.kind,  rsp_tuser);
         match_field("x",           want.x,     rsp_tdata[3:0]);
         match_field("y",           want.y,     rsp_tdata[11:4]);
         match_field("z",           want.z,     rsp_tdata[15:12]);
         match_field("face_dir",    want.dir,   rsp_tdata[18:16]);
         match_field("type_out",    want.blk,   rsp_tdata[22:19]);
         match_field("vertex_base", want.vbase, rsp_tdata[38:23]);
         match_field("face_total",  want.total, rsp_tdata[53:39]);
         match_field("overflow",    want.ovf,   rsp_tdata[54]);
         match_field("pad",         0,          rsp_tdata[55]);
         match_field("last",        want.last,  rsp_tlast);
      end
   endtask

   // Sample all channels at the edge; responses first so stray beats show up
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ChunkCells; i++) chunk_mem[i] = TypeAir;
         record_q.delete();
         faces_used = 0;
         ovf_seen   = 1'b0;
         water_type = TranslucentRst;
      end else begin
         if (rsp_tvalid && rsp_tready) compare_beat();
         if (req_tvalid && req_tready)
            predict_beat(action_type'(req_tuser), req_tdata[3:0], req_tdata[11:4],
                         req_tdata[15:12], req_tdata[19:16]);
         if (csr_valid && csr_ready) water_type = csr_data;
      end
      pending <= record_q.size();
      errors  <= fail_count;
   end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Stimulus and verdict for the voxel face culling mesher. A short directed
// run covers corners, water, enclosed and air blocks; random phases under
// several translucent settings follow, clustered in one corner of the chunk.
// ============================================================================
module tb;
   import vfcm_pkg::*;

   localparam int IdleLimit    = 200000;
   localparam int SettleCycles = 24;
   localparam int HoldCycles   = 300;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata;   // x, y, z, block type, pad from bit 0 up
   logic [1:0]          req_tuser;   // action
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;   // x, y, z, face_dir, type_out, vertex_base,
                                     // face_total, overflow, pad from bit 0 up
   logic [1:0]          rsp_tuser;   // kind
   logic                rsp_tlast;
   logic                csr_valid;
   logic                csr_ready;
   logic [TypeW-1:0]    csr_data;

   int               pending;
   int               errors;
   int               quiet = 0;
   bit               send_idle;
   bit               recv_idle;
   bit               hold_req;
   logic [TypeW-1:0] water_type;

   voxel_face_culling_mesher_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   face_mesh_checker mesh_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .pending    (pending),
      .errors     (errors)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // End the run when no channel moves a beat for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= IdleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // Response side: random stalls per beat when recv_idle is set, one long hold-off on request
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end
         stall = recv_idle ? $urandom_range(0, 14) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Offer one request beat, after a random gap when send_idle is set, and hold it until taken
   task automatic send_beat(action_type act, logic [CoordXW-1:0] bx,
                            logic [CoordYW-1:0] by, logic [CoordZW-1:0] bz,
                            logic [TypeW-1:0] bt);
      int gap;
      gap = send_idle ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {4'b0000, bt, bz, by, bx};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop offering and wait until every expected record is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_water_type(logic [TypeW-1:0] value);
      csr_valid  <= 1'b1;
      csr_data   <= value;
      water_type = value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Corners, water culling, enclosed and air blocks at the reset setting
   task automatic run_directed();
      send_beat(ACT_READ,   4'd0,  8'd0,   4'd0,  4'd0);
      send_beat(ACT_FINISH, 4'd0,  8'd0,   4'd0,  4'd0);
      // lone block in the far corner shows all faces
      send_beat(ACT_WRITE,  4'd15, 8'd255, 4'd15, 4'd15);
      send_beat(ACT_MESH,   4'd15, 8'd255, 4'd15, 4'd0);
      // stone at the origin with water beside it and stone above
      send_beat(ACT_WRITE,  4'd0,  8'd0,   4'd0,  4'd1);
      send_beat(ACT_WRITE,  4'd1,  8'd0,   4'd0,  TranslucentRst);
      send_beat(ACT_WRITE,  4'd0,  8'd1,   4'd0,  4'd2);
      send_beat(ACT_MESH,   4'd0,  8'd0,   4'd0,  4'd0);
      send_beat(ACT_MESH,   4'd1,  8'd0,   4'd0,  4'd0);
      // water next to water still shows the shared face
      send_beat(ACT_WRITE,  4'd2,  8'd0,   4'd0,  TranslucentRst);
      send_beat(ACT_MESH,   4'd1,  8'd0,   4'd0,  4'd0);
      send_beat(ACT_MESH,   4'd5,  8'd5,   4'd5,  4'd0);
      // fully enclosed block emits nothing
      send_beat(ACT_WRITE,  4'd8,  8'd8,   4'd8,  4'd3);
      send_beat(ACT_WRITE,  4'd7,  8'd8,   4'd8,  4'd4);
      send_beat(ACT_WRITE,  4'd9,  8'd8,   4'd8,  4'd5);
      send_beat(ACT_WRITE,  4'd8,  8'd7,   4'd8,  4'd7);
      send_beat(ACT_WRITE,  4'd8,  8'd9,   4'd8,  4'd8);
      send_beat(ACT_WRITE,  4'd8,  8'd8,   4'd7,  4'd9);
      send_beat(ACT_WRITE,  4'd8,  8'd8,   4'd9,  4'd10);
      send_beat(ACT_MESH,   4'd8,  8'd8,   4'd8,  4'd0);
      send_beat(ACT_READ,   4'd15, 8'd255, 4'd15, 4'd0);
      send_beat(ACT_FINISH, 4'd0,  8'd0,   4'd0,  4'd0);
   endtask

   // Random mix clustered in one corner of the chunk, some beats anywhere
   task automatic run_random_phase(logic [TypeW-1:0] cfg, int count, bit idle_on,
                                   bit with_hold);
      bit                 cx, cy, cz;
      int                 pick;
      action_type         act;
      logic [CoordXW-1:0] bx;
      logic [CoordYW-1:0] by;
      logic [CoordZW-1:0] bz;
      logic [TypeW-1:0]   bt;
      drain_results();
      write_water_type(cfg);
      send_idle = idle_on;
      recv_idle = idle_on;
      hold_req  = with_hold;
      cx = 1'($urandom_range(0, 1));
      cy = 1'($urandom_range(0, 1));
      cz = 1'($urandom_range(0, 1));
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         act  = (pick < 40) ? ACT_WRITE : (pick < 55) ? ACT_READ :
                (pick < 92) ? ACT_MESH : ACT_FINISH;
         if ($urandom_range(0, 99) < 15) begin
            bx = CoordXW'($urandom_range(0, 15));
            by = CoordYW'($urandom_range(0, 255));
            bz = CoordZW'($urandom_range(0, 15));
         end else begin
            bx = cx ? CoordXW'(15 - $urandom_range(0, 3)) : CoordXW'($urandom_range(0, 3));
            by = cy ? CoordYW'(255 - $urandom_range(0, 3)) : CoordYW'($urandom_range(0, 3));
            bz = cz ? CoordZW'(15 - $urandom_range(0, 3)) : CoordZW'($urandom_range(0, 3));
         end
         pick = $urandom_range(0, 99);
         bt   = (pick < 20) ? TypeAir : (pick < 45) ? water_type : TypeW'($urandom_range(1, 15));
         send_beat(act, bx, by, bz, bt);
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= ACT_WRITE;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      water_type = TranslucentRst;
      send_idle  = 1'b1;
      recv_idle  = 1'b1;
      hold_req   = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_random_phase(4'd0,  100, 1'b1, 1'b0);
      run_random_phase(4'd15, 100, 1'b1, 1'b1);
      run_random_phase(TypeW'($urandom_range(1, 14)), 105, 1'b0, 1'b0);
      run_random_phase(TranslucentRst, 105, 1'b1, 1'b0);
      drain_results();

      if (errors == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
